FILE: design/ikhm_pkg.sv
// shared types and constants for the integer-key hash map
// no dependencies; imported by the controller, the datapath and the top level
package ikhm_pkg;

    localparam int KEY_IN_W   = 32;
    localparam int VALUE_IN_W = 64;

    typedef enum logic [1:0] {
        OP_LOOKUP  = 2'd0,
        OP_PUT     = 2'd1,
        OP_PUT_NEW = 2'd2,
        OP_DELETE  = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STS_DONE   = 2'd0,
        STS_EXISTS = 2'd1,
        STS_FULL   = 2'd2
    } t_status;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic quot;
        logic rem;
        logic read;
        logic update;
        logic clear;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
    } t_stat;

endpackage

FILE: design/integer_key_hash_map.sv
// top level of the integer-key hash map with bounded buckets
// depends on ikhm_pkg, ikhm_ctrl and ikhm_datapath
//
// usage:
//   a request (i_op, i_key, i_value) is taken at a rising edge where start is
//   high and busy is low. ops: lookup, insert or replace, insert if absent,
//   delete. the bucket is key mod BUCKETS, each bucket holds WAYS entries.
//   exactly one result (o_hit, o_old_value, o_status) per request, shown for
//   one cycle with o_strobe high; the receiver cannot stall it.
// timing:
//   the result strobe and the drop of busy come in the same cycle, so a new
//   request is taken only after the result of the one before it.
//   the steps are: quotient multiply, remainder, bucket read of all ways,
//   compare and write back; the single-port bucket memories and the two
//   multiplies of the modulo make these separate steps.
// reset:
//   i_rst_n is synchronous, active low. after reset the valid marks are
//   cleared one bucket per cycle, all BUCKETS of them, with busy held high.
module integer_key_hash_map import ikhm_pkg::*; #(
    parameter int BUCKETS    = 128,
    parameter int WAYS       = 4,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            i_op,
    input  logic [KEY_IN_W-1:0]   i_key,
    input  logic [VALUE_IN_W-1:0] i_value,
    output logic                  o_strobe,
    output logic                  o_hit,
    output logic [VALUE_IN_W-1:0] o_old_value,
    output logic [1:0]            o_status
);

    t_cmd  cmd;
    t_stat stat;

    ikhm_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .busy     (busy),
        .o_strobe (o_strobe)
    );

    ikhm_datapath #(
        .BUCKETS    (BUCKETS),
        .WAYS       (WAYS),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_stat      (stat),
        .i_op        (i_op),
        .i_key       (i_key),
        .i_value     (i_value),
        .o_hit       (o_hit),
        .o_old_value (o_old_value),
        .o_status    (o_status)
    );

    // every accepted transaction gets its result strobe
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##5 o_strobe)
        else $error("result strobe missing after accepted request");

    // a result only ends a busy period
    a_strobe_after_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ($past(busy) && !busy))
        else $error("result strobe outside a request");

    // refusal codes agree with the hit flag
    a_status_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> ((o_status == STS_EXISTS && o_hit) ||
                      (o_status == STS_FULL && !o_hit) ||
                      (o_status == STS_DONE)))
        else $error("status code inconsistent with hit");

    // a miss never reports a stored value
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_hit) |-> (o_old_value == '0))
        else $error("old value nonzero on a miss");

endmodule

FILE: design/ikhm_ctrl.sv
// sequencer of the hash map: clearing pass after reset, then one request at a time
// depends on ikhm_pkg
module ikhm_ctrl import ikhm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  start,
    input  t_stat i_stat,
    output t_cmd  o_cmd,
    output logic  busy,
    output logic  o_strobe
);

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_QUOT,
        ST_REM,
        ST_READ,
        ST_UPD
    } t_state;

    t_state r_state, n_state;
    logic   r_busy;
    logic   r_strobe;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_stat.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_QUOT;
                end
            end
            ST_QUOT: begin
                o_cmd.quot = 1'b1;
                n_state    = ST_REM;
            end
            ST_REM: begin
                o_cmd.rem = 1'b1;
                n_state   = ST_READ;
            end
            ST_READ: begin
                o_cmd.read = 1'b1;
                n_state    = ST_UPD;
            end
            ST_UPD: begin
                o_cmd.update = 1'b1;
                n_state      = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_CLEAR;
            r_busy   <= 1'b1;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_busy   <= (n_state != ST_IDLE);
            r_strobe <= (r_state == ST_UPD);
        end
    end

    assign busy     = r_busy;
    assign o_strobe = r_strobe;

endmodule

FILE: design/ikhm_datapath.sv
// bucket index unit, per-way key/value memories, valid-row memory and update logic
// depends on ikhm_pkg; driven by ikhm_ctrl
module ikhm_datapath import ikhm_pkg::*; #(
    parameter int BUCKETS    = 128,
    parameter int WAYS       = 4,
    parameter int KEY_BITS   = 32,
    parameter int VALUE_BITS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_stat                 o_stat,
    input  logic [1:0]            i_op,
    input  logic [KEY_IN_W-1:0]   i_key,
    input  logic [VALUE_IN_W-1:0] i_value,
    output logic                  o_hit,
    output logic [VALUE_IN_W-1:0] o_old_value,
    output logic [1:0]            o_status
);

    localparam int KEY_W = (KEY_BITS < KEY_IN_W) ? KEY_BITS : KEY_IN_W;
    localparam int BKT_W = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int RW    = BKT_W + 1;
    localparam int PW    = KEY_W + 33;
    // floor(2^32 / BUCKETS): quotient estimate is exact or one low
    localparam logic [32:0] RECIP = 33'((65'd1 << 32) / BUCKETS);

    t_op                   r_op;
    logic [KEY_W-1:0]      r_key;
    logic [VALUE_BITS-1:0] r_value;
    logic [KEY_W-1:0]      r_quot;
    logic [RW-1:0]         r_rem;
    logic [BKT_W-1:0]      r_bucket;
    logic [BKT_W-1:0]      r_clr_idx;

    logic [WAYS-1:0]       r_valid_mem [BUCKETS];
    logic [WAYS-1:0]       r_valid_rd;
    logic [KEY_W-1:0]      r_key_rd [WAYS];
    logic [VALUE_BITS-1:0] r_val_rd [WAYS];

    logic                  r_hit;
    logic [VALUE_BITS-1:0] r_old;
    t_status               r_status;

    logic [PW-1:0]         prod;
    logic [KEY_W:0]        diff;
    logic [BKT_W-1:0]      bucket;

    logic [WAYS-1:0]       match, free_w, found_oh, free_oh;
    logic [WAYS-1:0]       wr_key_oh, wr_val_oh, valid_new;
    logic                  valid_we, found, has_free;
    logic [VALUE_BITS-1:0] old_val;
    t_status               status;

    // key mod BUCKETS by reciprocal multiply, then one correction step
    assign prod   = PW'(r_key) * PW'(RECIP);
    assign diff   = {1'b0, r_key} - (KEY_W + 1)'(r_quot * BUCKETS);
    assign bucket = (r_rem >= RW'(BUCKETS)) ? BKT_W'(r_rem - RW'(BUCKETS)) : BKT_W'(r_rem);

    assign o_stat.clr_last = (r_clr_idx == BKT_W'(BUCKETS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_idx <= '0;
        end else if (i_cmd.clear) begin
            r_clr_idx <= r_clr_idx + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op    <= t_op'(i_op);
            r_key   <= i_key[KEY_W-1:0];
            r_value <= i_value[VALUE_BITS-1:0];
        end
        if (i_cmd.quot) r_quot <= prod[KEY_W+31:32];
        if (i_cmd.rem)  r_rem  <= RW'(diff);
        if (i_cmd.read) r_bucket <= bucket;
    end

    always_comb begin
        match     = '0;
        free_w    = '0;
        old_val   = '0;
        for (int w = 0; w < WAYS; w++) begin
            match[w]  = r_valid_rd[w] && (r_key_rd[w] == r_key);
            free_w[w] = !r_valid_rd[w];
        end
        // lowest set bit
        found_oh = match & (~match + WAYS'(1));
        free_oh  = free_w & (~free_w + WAYS'(1));
        for (int w = 0; w < WAYS; w++) begin
            if (found_oh[w]) old_val = old_val | r_val_rd[w];
        end
        found     = |match;
        has_free  = |free_w;
        wr_key_oh = '0;
        wr_val_oh = '0;
        valid_new = r_valid_rd;
        valid_we  = 1'b0;
        status    = STS_DONE;
        case (r_op)
            OP_LOOKUP: ;
            OP_PUT, OP_PUT_NEW: begin
                if (found) begin
                    if (r_op == OP_PUT) wr_val_oh = found_oh;
                    else                status    = STS_EXISTS;
                end else if (has_free) begin
                    wr_key_oh = free_oh;
                    wr_val_oh = free_oh;
                    valid_new = r_valid_rd | free_oh;
                    valid_we  = 1'b1;
                end else begin
                    status = STS_FULL;
                end
            end
            OP_DELETE: begin
                if (found) begin
                    valid_new = r_valid_rd & ~found_oh;
                    valid_we  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.clear) begin
            r_valid_mem[r_clr_idx] <= '0;
        end else if (i_cmd.update && valid_we) begin
            r_valid_mem[r_bucket] <= valid_new;
        end
        if (i_cmd.read) r_valid_rd <= r_valid_mem[bucket];
    end

    for (genvar w = 0; w < WAYS; w++) begin : g_way
        logic [KEY_W-1:0]      r_key_mem [BUCKETS];
        logic [VALUE_BITS-1:0] r_val_mem [BUCKETS];

        always_ff @(posedge i_clk) begin
            if (i_cmd.update && wr_key_oh[w]) r_key_mem[r_bucket] <= r_key;
            if (i_cmd.update && wr_val_oh[w]) r_val_mem[r_bucket] <= r_value;
            if (i_cmd.read) begin
                r_key_rd[w] <= r_key_mem[bucket];
                r_val_rd[w] <= r_val_mem[bucket];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.update) begin
            r_hit    <= found;
            r_old    <= old_val;
            r_status <= status;
        end
    end

    assign o_hit       = r_hit;
    assign o_old_value = VALUE_IN_W'(r_old);
    assign o_status    = r_status;

endmodule

FILE: sim/tb_integer_key_hash_map.sv
// self-checking testbench for the integer-key hash map with bounded buckets
// drives request transactions through a queue-fed driver and predicts each result;
// depends on ikhm_pkg and integer_key_hash_map
`timescale 1ns / 100ps

module tb_integer_key_hash_map import ikhm_pkg::*; ();

    localparam int BUCKETS    = 128;
    localparam int WAYS       = 4;
    localparam int KEY_BITS   = 32;
    localparam int VALUE_BITS = 64;
    localparam int SLOTS      = BUCKETS * WAYS;
    localparam int DRAIN_WAIT = 20;

    typedef struct {
        t_op                    op;
        logic [KEY_IN_W-1:0]    key;
        logic [VALUE_IN_W-1:0]  value;
        int                     idle_pct;
        bit                     drain;
    } t_map_req;

    typedef struct {
        logic                   hit;
        logic [VALUE_IN_W-1:0]  old_value;
        t_status                status;
    } t_map_resp;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   start;
    logic                   busy;
    logic [1:0]             i_op;
    logic [KEY_IN_W-1:0]    i_key;
    logic [VALUE_IN_W-1:0]  i_value;
    logic                   o_strobe;
    logic                   o_hit;
    logic [VALUE_IN_W-1:0]  o_old_value;
    logic [1:0]             o_status;

    // predicted contents of the map
    bit                     slot_valid [SLOTS];
    logic [KEY_IN_W-1:0]    slot_key   [SLOTS];
    logic [VALUE_IN_W-1:0]  slot_value [SLOTS];

    t_map_req               pending_reqs[$];
    t_map_resp              expected_resps[$];
    t_map_req               cur_req;
    int                     gap_left;
    int                     outstanding;
    int unsigned            errors;
    logic [KEY_IN_W-1:0]    key_pool[48];

    integer_key_hash_map #(
        .BUCKETS    (BUCKETS),
        .WAYS       (WAYS),
        .KEY_BITS   (KEY_BITS),
        .VALUE_BITS (VALUE_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_op        (i_op),
        .i_key       (i_key),
        .i_value     (i_value),
        .o_strobe    (o_strobe),
        .o_hit       (o_hit),
        .o_old_value (o_old_value),
        .o_status    (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // applies one request to the predicted map and returns its result
    task automatic map_apply(input t_map_req r, output t_map_resp res);
        int base;
        int found;
        int free_way;
        int s;
        base     = (r.key % BUCKETS) * WAYS;
        found    = -1;
        free_way = -1;
        res.hit       = 1'b0;
        res.old_value = '0;
        res.status    = STS_DONE;
        for (int w = 0; w < WAYS; w++) begin
            s = base + w;
            if (slot_valid[s]) begin
                if (found < 0 && slot_key[s] == r.key)
                    found = w;
            end else if (free_way < 0) begin
                free_way = w;
            end
        end
        if (found >= 0) begin
            s = base + found;
            res.hit       = 1'b1;
            res.old_value = slot_value[s];
            case (r.op)
                OP_PUT:     slot_value[s] = r.value;
                OP_PUT_NEW: res.status = STS_EXISTS;
                OP_DELETE:  slot_valid[s] = 1'b0;
                default: ;
            endcase
        end else if (r.op == OP_PUT || r.op == OP_PUT_NEW) begin
            if (free_way >= 0) begin
                s = base + free_way;
                slot_valid[s] = 1'b1;
                slot_key[s]   = r.key;
                slot_value[s] = r.value;
            end else begin
                res.status = STS_FULL;
            end
        end
    endtask

    // driver: one transaction per start/busy handshake
    always @(posedge i_clk) begin
        t_map_resp res;
        bit        accepted;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            accepted = start && !busy;
            outstanding = outstanding + (accepted ? 1 : 0) - (o_strobe ? 1 : 0);
            if (accepted) begin
                map_apply(cur_req, res);
                expected_resps.push_back(res);
                gap_left = ($urandom_range(0, 99) < cur_req.idle_pct) ?
                           $urandom_range(1, 12) : 0;
            end
            if (!start || accepted) begin
                if (gap_left > 0) begin
                    gap_left--;
                    start <= 1'b0;
                end else if (pending_reqs.size() > 0 &&
                             (!pending_reqs[0].drain || outstanding == 0)) begin
                    cur_req = pending_reqs.pop_front();
                    start   <= 1'b1;
                    i_op    <= cur_req.op;
                    i_key   <= cur_req.key;
                    i_value <= cur_req.value;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: results cannot be held off, check each one on its strobe
    always @(posedge i_clk) begin
        t_map_resp want;
        if (i_rst_n && o_strobe) begin
            if (expected_resps.size() == 0) begin
                $error("result with no request pending: hit %0b old_value %h status %0d",
                       o_hit, o_old_value, o_status);
                errors++;
            end else begin
                want = expected_resps.pop_front();
                if (o_hit !== want.hit) begin
                    $error("hit: expected %0b, actual %0b", want.hit, o_hit);
                    errors++;
                end
                if (o_old_value !== want.old_value) begin
                    $error("old_value: expected %h, actual %h", want.old_value, o_old_value);
                    errors++;
                end
                if (o_status !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, o_status);
                    errors++;
                end
            end
        end
    end

    function automatic void add_req(t_op op, logic [KEY_IN_W-1:0] key,
                                    logic [VALUE_IN_W-1:0] value, int idle_pct, bit drain);
        t_map_req r;
        r.op       = op;
        r.key      = key;
        r.value    = value;
        r.idle_pct = idle_pct;
        r.drain    = drain;
        pending_reqs.push_back(r);
    endfunction

    initial begin
        int hot_buckets[6];
        int phase_idle[4];
        int sel;
        logic [KEY_IN_W-1:0]   key;
        logic [VALUE_IN_W-1:0] value;

        hot_buckets = '{0, 1, 63, 64, 126, 127};
        phase_idle  = '{0, 69, 0, 33};
        start       = 1'b0;
        i_op        = OP_LOOKUP;
        i_key       = '0;
        i_value     = '0;
        i_rst_n     = 1'b0;
        gap_left    = 0;
        outstanding = 0;
        errors      = 0;
        for (int s = 0; s < SLOTS; s++) begin
            slot_valid[s] = 1'b0;
            slot_key[s]   = '0;
            slot_value[s] = '0;
        end
        // eight keys per hot bucket so buckets overflow
        for (int i = 0; i < 48; i++)
            key_pool[i] = ($urandom() & ~32'h7f) | hot_buckets[i % 6];

        // directed: empty map, replace, exists, delete twice, full bucket
        add_req(OP_LOOKUP,  32'h0, 64'h0, 0, 1'b0);
        add_req(OP_PUT,     32'h0, '1, 0, 1'b0);
        add_req(OP_PUT,     32'h0, 64'h0123_4567_89ab_cdef, 0, 1'b0);
        add_req(OP_PUT_NEW, 32'h0, 64'h5555_5555_5555_5555, 0, 1'b0);
        add_req(OP_LOOKUP,  32'h0, '1, 0, 1'b0);
        add_req(OP_DELETE,  32'h0, 64'h0, 0, 1'b0);
        add_req(OP_DELETE,  32'h0, 64'h0, 0, 1'b0);
        add_req(OP_PUT_NEW, 32'h8000_0000, 64'h8000_0000_0000_0000, 0, 1'b0);
        add_req(OP_PUT,     32'd127, 64'h1, 0, 1'b0);
        add_req(OP_PUT_NEW, 32'd255, 64'h2, 0, 1'b0);
        add_req(OP_PUT,     32'hffff_ffff, '1, 0, 1'b0);
        add_req(OP_PUT_NEW, 32'd383, 64'h0, 0, 1'b0);
        add_req(OP_PUT,     32'd511, 64'h3, 0, 1'b0);
        add_req(OP_PUT_NEW, 32'd639, 64'h4, 0, 1'b0);
        add_req(OP_DELETE,  32'd255, 64'h0, 0, 1'b0);
        add_req(OP_PUT_NEW, 32'd639, 64'h6, 0, 1'b0);
        add_req(OP_LOOKUP,  32'hffff_ffff, 64'h0, 0, 1'b0);
        add_req(OP_LOOKUP,  32'd639, 64'h0, 0, 1'b0);
        add_req(OP_DELETE,  32'd639, 64'h0, 0, 1'b0);
        add_req(OP_LOOKUP,  32'h8000_0000, 64'h0, 0, 1'b0);

        for (int ph = 0; ph < 4; ph++) begin
            for (int n = 0; n < 310; n++) begin
                sel = $urandom_range(0, 99);
                if (sel < 70)
                    key = key_pool[$urandom_range(0, 47)];
                else if (sel < 85)
                    key = ($urandom() & ~32'h7f) | hot_buckets[$urandom_range(0, 5)];
                else
                    key = $urandom();
                sel = $urandom_range(0, 99);
                if (sel < 5)
                    value = '0;
                else if (sel < 10)
                    value = '1;
                else
                    value = {$urandom(), $urandom()};
                add_req(t_op'($urandom_range(0, 3)), key, value, phase_idle[ph],
                        n == 0 || $urandom_range(0, 99) < 2);
            end
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_reqs.size() == 0 && !start && outstanding == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (expected_resps.size() != 0) begin
            $error("%0d results never arrived", expected_resps.size());
            errors++;
        end
        if (errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule

FILE: files.f
design/ikhm_pkg.sv
design/ikhm_ctrl.sv
design/ikhm_datapath.sv
design/integer_key_hash_map.sv
sim/tb_integer_key_hash_map.sv
